>>> hdl/ateng_pkg.sv
// Shared types, constants and a helper function for the ANSI text cursor engine.
package ateng_pkg;

  // Widest pane the cursor logic supports, in text columns.
  localparam int MAX_COLS = 160;
  localparam int EndW     = $clog2(MAX_COLS + 1);

  // Character codes.
  localparam logic [7:0] ESC_BYTE   = 8'd27;
  localparam logic [7:0] LF_BYTE    = 8'd10;
  localparam logic [7:0] TAB_BYTE   = 8'd9;
  localparam logic [7:0] LBRACKET   = 8'h5B;
  localparam logic [7:0] SEMICOLON  = 8'h3B;
  localparam logic [7:0] SGR_FINAL  = 8'h6D;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [7:0] FINAL_LO   = 8'h40;
  localparam logic [7:0] FINAL_HI   = 8'h7E;
  localparam logic [7:0] PRINT_LO   = 8'h20;

  // Colors.
  localparam logic [7:0] COLOR_RESET = 8'h07;
  localparam logic [7:0] COLOR_LITE  = 8'h0F;
  localparam logic [7:0] BRIGHT_BIT  = 8'h08;

  // SGR parameter handling.
  localparam logic [9:0]  SGR_SAT      = 10'd1023;
  localparam logic [9:0]  SGR_FG_LO    = 10'd30;
  localparam logic [9:0]  SGR_FG_HI    = 10'd37;
  localparam logic [9:0]  SGR_BRIGHT_LO = 10'd90;
  localparam logic [9:0]  SGR_BRIGHT_HI = 10'd97;

  // Configuration register indexes.
  localparam logic [7:0] REG_PANE_FIRST  = 8'd0;
  localparam logic [7:0] REG_END_COL     = 8'd1;
  localparam logic [7:0] REG_ROW_LIMIT   = 8'd2;
  localparam logic [7:0] REG_FORCE_WHITE = 8'd3;

  // What the back end must do with an item.
  typedef enum logic [1:0] {
    KIND_SKIP    = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_TAB     = 2'd2,
    KIND_CELL    = 2'd3
  } item_kind_t;

  // One classified item as it travels through the queue.
  typedef struct packed {
    item_kind_t kind;
    logic       printable;
    logic [7:0] glyph;
    logic [7:0] color;
  } queue_item_t;

  // Pane geometry seen by the cursor logic.
  typedef struct packed {
    logic [7:0] first_col;
    logic [7:0] end_col;
    logic [7:0] row_limit;
  } pane_cfg_t;

  // ANSI color number to VGA color number.
  function automatic logic [2:0] sgr_palette(input logic [2:0] idx);
    logic [2:0] res;
    unique case (idx)
      3'd0: res = 3'd0;
      3'd1: res = 3'd4;
      3'd2: res = 3'd2;
      3'd3: res = 3'd6;
      3'd4: res = 3'd1;
      3'd5: res = 3'd5;
      3'd6: res = 3'd3;
      3'd7: res = 3'd7;
      default: res = 3'd0;
    endcase
    return res;
  endfunction

endpackage

>>> hdl/ateng_front.sv
// Front end: escape sequence parser, SGR color tracking and item classification.
module ateng_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           char_byte,
  input  logic                 force_white,
  output ateng_pkg::queue_item_t item
);
  import ateng_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ESC  = 3'b010,
    PH_CSI  = 3'b100
  } phase_t;

  phase_t      phase, phase_next;
  logic [9:0]  sgr_value, sgr_value_next;
  logic        value_seen, value_seen_next;
  logic [7:0]  text_color, text_color_next;
  logic        sw;

  logic [13:0] sgr_acc;
  logic [9:0]  sgr_off;
  logic [7:0]  bg;
  logic        is_digit;

  // Decimal accumulate: value * 10 + digit, saturating.
  assign sgr_acc  = {1'b0, sgr_value, 3'b000} + {3'b000, sgr_value, 1'b0}
                  + {10'd0, char_byte[3:0]};
  assign is_digit = (char_byte >= DIGIT_ZERO) && (char_byte <= DIGIT_NINE);
  assign bg       = {text_color[7:4], 4'h0};
  assign sgr_off  = (sgr_value >= SGR_BRIGHT_LO) ? sgr_value - SGR_BRIGHT_LO
                                                 : sgr_value - SGR_FG_LO;

  // Parser step for the current byte.
  always_comb begin
    phase_next      = phase;
    sgr_value_next  = sgr_value;
    value_seen_next = value_seen;
    text_color_next = text_color;
    sw              = 1'b0;
    unique case (phase)
      PH_ESC: begin
        if (char_byte == LBRACKET) begin
          phase_next      = PH_CSI;
          sgr_value_next  = 10'd0;
          value_seen_next = 1'b0;
          sw              = 1'b1;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_CSI: begin
        sw = 1'b1;
        priority if (is_digit) begin
          sgr_value_next  = (sgr_acc > {4'd0, SGR_SAT}) ? SGR_SAT : sgr_acc[9:0];
          value_seen_next = 1'b1;
        end else if (char_byte == SEMICOLON) begin
          // A zero parameter closed by a separator resets the color.
          if (value_seen && (sgr_value == 10'd0)) begin
            text_color_next = force_white ? COLOR_LITE : COLOR_RESET;
          end
          sgr_value_next  = 10'd0;
          value_seen_next = 1'b0;
        end else if (char_byte == SGR_FINAL) begin
          phase_next = PH_IDLE;
          if (value_seen) begin
            if (sgr_value == 10'd0) begin
              text_color_next = force_white ? COLOR_LITE : COLOR_RESET;
            end else if ((sgr_value >= SGR_FG_LO) && (sgr_value <= SGR_FG_HI)) begin
              text_color_next = force_white ? COLOR_LITE
                              : (bg | {5'd0, sgr_palette(sgr_off[2:0])});
            end else if ((sgr_value >= SGR_BRIGHT_LO) && (sgr_value <= SGR_BRIGHT_HI)) begin
              text_color_next = force_white ? COLOR_LITE
                              : (bg | BRIGHT_BIT | {5'd0, sgr_palette(sgr_off[2:0])});
            end
          end
        end else if ((char_byte >= FINAL_LO) && (char_byte <= FINAL_HI)) begin
          phase_next = PH_IDLE;
        end else if (char_byte < PRINT_LO) begin
          // A control byte aborts the sequence and passes through as text.
          phase_next = PH_IDLE;
          sw         = 1'b0;
        end
      end
      PH_IDLE: begin
        if (char_byte == ESC_BYTE) begin
          phase_next = PH_ESC;
          sw         = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Classify the item for the cursor logic.
  always_comb begin
    item.glyph     = char_byte;
    item.color     = text_color;
    item.printable = (char_byte >= PRINT_LO) && (char_byte <= FINAL_HI);
    priority if (sw) begin
      item.kind = KIND_SKIP;
    end else if (char_byte == LF_BYTE) begin
      item.kind = KIND_NEWLINE;
    end else if (char_byte == TAB_BYTE) begin
      item.kind = KIND_TAB;
    end else begin
      item.kind = KIND_CELL;
    end
  end

  // Parser and color registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      sgr_value  <= 10'd0;
      value_seen <= 1'b0;
      text_color <= COLOR_LITE;
    end else if (accept) begin
      phase      <= phase_next;
      sgr_value  <= sgr_value_next;
      value_seen <= value_seen_next;
      text_color <= text_color_next;
    end
  end

endmodule

>>> hdl/ateng_queue.sv
// Two-entry queue of classified items between the front and back ends.
module ateng_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  ateng_pkg::queue_item_t push_item,
  input  logic                  pop,
  output ateng_pkg::queue_item_t head,
  output logic                  full,
  output logic                  not_empty
);
  import ateng_pkg::*;

  queue_item_t slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> hdl/ateng_back.sv
// Back end: cursor movement, scroll detection and the registered result item.
module ateng_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  ateng_pkg::queue_item_t q_item,
  output logic                   q_pop,
  input  ateng_pkg::pane_cfg_t   pane,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   draw_cell,
  output logic [7:0]             glyph,
  output logic [7:0]             cell_color,
  output logic [7:0]             cell_col,
  output logic [7:0]             cell_row,
  output logic                   scroll_up,
  output logic [7:0]             cursor_col,
  output logic [7:0]             cursor_row,
  output logic                   swallowed
);
  import ateng_pkg::*;

  logic [7:0]      cur_col, cur_col_next;
  logic [7:0]      cur_row, cur_row_next;
  logic            scroll;
  logic            wrap;
  logic            draw;

  logic [EndW-1:0] end_col;
  logic [8:0]      row_inc;
  logic            row_scroll;
  logic [7:0]      wrap_row;
  logic [7:0]      tab_dist;
  logic [9:0]      tab_col;
  logic [8:0]      cell_next;

  // Load the result register when it is empty or being taken.
  assign q_pop = q_valid && (!out_valid || !out_stall);

  // Pane end limited to the widest supported pane.
  always_comb begin
    if ({{(EndW > 8 ? EndW - 8 : 1){1'b0}}, pane.end_col} > (EndW + 1)'(MAX_COLS)) begin
      end_col = EndW'(MAX_COLS);
    end else begin
      end_col = EndW'(pane.end_col);
    end
  end

  // Next-row move with scroll and pinning at the last row.
  assign row_inc    = {1'b0, cur_row} + 9'd1;
  assign row_scroll = row_inc >= {1'b0, pane.row_limit};
  always_comb begin
    if (!row_scroll) begin
      wrap_row = row_inc[7:0];
    end else if (pane.row_limit == 8'd0) begin
      wrap_row = 8'd0;
    end else begin
      wrap_row = pane.row_limit - 8'd1;
    end
  end

  // Tab stop and single-cell advance targets.
  assign tab_dist  = cur_col - pane.first_col;
  assign tab_col   = {({2'b00, tab_dist} + 10'd4) & ~10'd3} + {2'b00, pane.first_col};
  assign cell_next = {1'b0, cur_col} + 9'd1;

  // Cursor update for the item at the head of the queue.
  always_comb begin
    wrap         = 1'b0;
    draw         = 1'b0;
    cur_col_next = cur_col;
    unique case (q_item.kind)
      KIND_SKIP: begin
        wrap = 1'b0;
      end
      KIND_NEWLINE: begin
        wrap = 1'b1;
      end
      KIND_TAB: begin
        if (tab_col >= 10'(end_col)) begin
          wrap = 1'b1;
        end else begin
          cur_col_next = tab_col[7:0];
        end
      end
      KIND_CELL: begin
        draw = q_item.printable;
        if (cell_next >= 9'(end_col)) begin
          wrap = 1'b1;
        end else begin
          cur_col_next = cell_next[7:0];
        end
      end
      default: begin
        wrap = 1'b0;
      end
    endcase
    scroll       = wrap && row_scroll;
    cur_row_next = wrap ? wrap_row : cur_row;
    if (wrap) begin
      cur_col_next = pane.first_col;
    end
  end

  // Cursor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= 8'd0;
      cur_row <= 8'd0;
    end else if (q_pop) begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      draw_cell  <= draw;
      glyph      <= draw ? q_item.glyph : 8'd0;
      cell_color <= draw ? q_item.color : 8'd0;
      cell_col   <= draw ? cur_col : 8'd0;
      cell_row   <= draw ? cur_row : 8'd0;
      scroll_up  <= scroll;
      cursor_col <= cur_col_next;
      cursor_row <= cur_row_next;
      swallowed  <= (q_item.kind == KIND_SKIP);
    end
  end

endmodule

>>> hdl/ansi_text_cursor_engine.sv
// Top level of the ANSI text cursor engine: configuration registers and wiring.
//
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid / in_stall   char_byte
//  out      output     out_valid / out_stall draw_cell, glyph, cell_color, cell_col,
//                                            cell_row, scroll_up, cursor_col,
//                                            cursor_row, swallowed
//  cfg      input      cfg_we                cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low. Each byte yields one result
// item (parser into the queue, then the cursor unit into the result register).
// If out_stall is low, the cursor unit takes one entry per cycle: the sustained rate.
// Reset is synchronous and returns parser, color, cursor and queue to their start.
// A stall on the output holds the result; the two-entry queue absorbs the front end
// until it fills, and then in_stall rises.
module ansi_text_cursor_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       draw_cell,
  output logic [7:0] glyph,
  output logic [7:0] cell_color,
  output logic [7:0] cell_col,
  output logic [7:0] cell_row,
  output logic       scroll_up,
  output logic [7:0] cursor_col,
  output logic [7:0] cursor_row,
  output logic       swallowed,
  input  logic       cfg_we,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import ateng_pkg::*;

  pane_cfg_t   pane;
  logic        force_white;
  logic        accept;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  queue_item_t front_item;
  queue_item_t head_item;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pane.first_col <= 8'd0;
      pane.end_col   <= 8'd80;
      pane.row_limit <= 8'd58;
      force_white    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PANE_FIRST:  pane.first_col <= cfg_data;
        REG_END_COL:     pane.end_col   <= cfg_data;
        REG_ROW_LIMIT:   pane.row_limit <= cfg_data;
        REG_FORCE_WHITE: force_white    <= cfg_data[0];
        default: begin
          force_white <= force_white;
        end
      endcase
    end
  end

  // Parser and classifier.
  ateng_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .char_byte   (char_byte),
    .force_white (force_white),
    .item        (front_item)
  );

  // Decoupling queue.
  ateng_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (head_item),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Cursor unit and result register.
  ateng_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_not_empty),
    .q_item     (head_item),
    .q_pop      (q_pop),
    .pane       (pane),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .draw_cell  (draw_cell),
    .glyph      (glyph),
    .cell_color (cell_color),
    .cell_col   (cell_col),
    .cell_row   (cell_row),
    .scroll_up  (scroll_up),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .swallowed  (swallowed)
  );

endmodule
